>>> hdl/ltsc_pkg.sv
// ----------------------------------------------------------------------------
// Line tracking steering controller package
// Shared types, register indexes and reset values for the controller.
// ----------------------------------------------------------------------------
package ltsc_pkg;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;
    localparam int POWER_W    = 7;
    localparam int CMD_W      = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_BASE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_BASE = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SOFT_CORR  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HARD_CORR  = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_POWER  = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM    = 8'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LOST_DELAY = 8'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE    = 8'd7;

    localparam logic [POWER_W-1:0] RST_LEFT_BASE  = 7'd50;
    localparam logic [POWER_W-1:0] RST_RIGHT_BASE = 7'd50;
    localparam logic [POWER_W-1:0] RST_SOFT_CORR  = 7'd15;
    localparam logic [POWER_W-1:0] RST_HARD_CORR  = 7'd30;
    localparam logic [POWER_W-1:0] RST_MIN_POWER  = 7'd35;
    localparam logic [3:0]         RST_CONFIRM    = 4'd2;
    localparam logic [7:0]         RST_LOST_DELAY = 8'd0;

    localparam logic [POWER_W-1:0] POWER_MAX = 7'd100;

    typedef enum logic [2:0] {
        CLS_CENTER    = 3'd0,
        CLS_LEFT      = 3'd1,
        CLS_RIGHT     = 3'd2,
        CLS_FAR_LEFT  = 3'd3,
        CLS_FAR_RIGHT = 3'd4,
        CLS_LOST      = 3'd5,
        CLS_AMBIG     = 3'd6
    } t_class;

    typedef enum logic [2:0] {
        ST_STOPPED     = 3'd0,
        ST_TRACK       = 3'd1,
        ST_CORR_LEFT   = 3'd2,
        ST_CORR_RIGHT  = 3'd3,
        ST_RECOV_LEFT  = 3'd4,
        ST_RECOV_RIGHT = 3'd5,
        ST_LOST_FWD    = 3'd6,
        ST_FAULT       = 3'd7
    } t_state;

    typedef struct packed {
        logic [POWER_W-1:0] left_base;
        logic [POWER_W-1:0] right_base;
        logic [POWER_W-1:0] soft_corr;
        logic [POWER_W-1:0] hard_corr;
        logic [POWER_W-1:0] min_power;
        logic [3:0]         confirm;
        logic [7:0]         lost_delay;
        logic               reverse;
    } t_cfg;

endpackage

>>> hdl/ltsc_cmd.sv
// ----------------------------------------------------------------------------
// Wheel command unit
// Turns a tracking state and the power registers into signed wheel commands.
// ----------------------------------------------------------------------------
module ltsc_cmd
    import ltsc_pkg::*;
(
    input  t_state                  i_state,
    input  t_cfg                    i_cfg,
    output logic signed [CMD_W-1:0] o_left,
    output logic signed [CMD_W-1:0] o_right
);

    function automatic logic [POWER_W-1:0] usable(
        input logic signed [9:0]    p,
        input logic [POWER_W-1:0]   lo
    );
        logic signed [9:0] q;
        q = p;
        if (p <= 10'sd0) begin
            q = 10'sd0;
        end else begin
            if (p < $signed({3'b000, lo})) begin
                q = $signed({3'b000, lo});
            end
            if (q > $signed({3'b000, POWER_MAX})) begin
                q = $signed({3'b000, POWER_MAX});
            end
        end
        return q[POWER_W-1:0];
    endfunction

    logic                     steer;
    logic                     to_left;
    logic [POWER_W-1:0]       corr;
    logic signed [9:0]        l_sum;
    logic signed [9:0]        r_sum;
    logic [POWER_W-1:0]       l_pow;
    logic [POWER_W-1:0]       r_pow;

    always_comb begin
        steer   = 1'b1;
        to_left = 1'b0;
        corr    = '0;
        unique case (i_state)
            ST_TRACK, ST_LOST_FWD: begin
                corr = '0;
            end
            ST_CORR_LEFT: begin
                to_left = 1'b1;
                corr    = i_cfg.soft_corr;
            end
            ST_CORR_RIGHT: begin
                corr = i_cfg.soft_corr;
            end
            ST_RECOV_LEFT: begin
                to_left = 1'b1;
                corr    = i_cfg.hard_corr;
            end
            ST_RECOV_RIGHT: begin
                corr = i_cfg.hard_corr;
            end
            default: begin
                steer = 1'b0;
            end
        endcase

        if (to_left ^ i_cfg.reverse) begin
            l_sum = $signed({3'b000, i_cfg.left_base})  - $signed({3'b000, corr});
            r_sum = $signed({3'b000, i_cfg.right_base}) + $signed({3'b000, corr});
        end else begin
            l_sum = $signed({3'b000, i_cfg.left_base})  + $signed({3'b000, corr});
            r_sum = $signed({3'b000, i_cfg.right_base}) - $signed({3'b000, corr});
        end

        l_pow = usable(l_sum, i_cfg.min_power);
        r_pow = usable(r_sum, i_cfg.min_power);

        if (steer) begin
            o_left  = $signed({1'b0, l_pow});
            o_right = -$signed({1'b0, r_pow});
        end else begin
            o_left  = '0;
            o_right = '0;
        end
    end

endmodule

>>> hdl/line_tracking_steering_controller_core.sv
// ----------------------------------------------------------------------------
// Line tracking steering controller
// Classifies a four-sensor mask, filters it, runs the tracking machine and
// produces signed wheel commands once per control tick.
// ----------------------------------------------------------------------------
// The block takes one control tick per clock cycle and returns its result in the
// next cycle from a single result register. A new request is taken whenever
// that register is empty or is being drained in the same cycle, so with the
// output side always ready the block sustains one tick per cycle. The state
// update for a tick is finished at the edge that takes it, so the next tick
// follows without a gap. Configuration writes are always accepted.
module line_tracking_steering_controller_core
    import ltsc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // s_axis tdata: [3:0] sensor mask, [4] button_event, [7:5] zero
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,
    // m_axis tdata: [2:0] line_state, [3] running, [6:4] observation,
    // [14:7] left wheel power, [22:15] right wheel power, [23] zero
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [23:0]           m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    function automatic t_class classify(input logic [3:0] m);
        t_class c;
        if (m == 4'b0000) begin
            c = CLS_LOST;
        end else if (m[3] && m[0]) begin
            c = CLS_AMBIG;
        end else if (m[2] && m[1]) begin
            c = CLS_CENTER;
        end else if ((m[3] && m[1]) || (m[0] && m[2])) begin
            c = CLS_AMBIG;
        end else if (m[3]) begin
            c = CLS_FAR_LEFT;
        end else if (m[0]) begin
            c = CLS_FAR_RIGHT;
        end else if (m[2]) begin
            c = CLS_LEFT;
        end else begin
            c = CLS_RIGHT;
        end
        return c;
    endfunction

    t_cfg         r_cfg;
    logic         r_run;
    t_state       r_state;
    logic         r_primed;
    t_class       r_cand;
    t_class       r_stable;
    logic [3:0]   r_reps;
    logic [7:0]   r_lost_ticks;
    logic         r_lost_act;
    logic         r_out_valid;
    logic [23:0]  r_out_data;

    logic         n_run;
    t_state       n_state;
    logic         n_primed;
    t_class       n_cand;
    t_class       n_stable;
    logic [3:0]   n_reps;
    logic [7:0]   n_lost_ticks;
    logic         n_lost_act;

    logic         in_accept;
    logic [3:0]   mask;
    logic         button;
    t_class       meas;
    t_class       obs;
    logic [3:0]   need;
    logic [7:0]   lost_count;

    logic signed [CMD_W-1:0] left_cmd;
    logic signed [CMD_W-1:0] right_cmd;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign mask   = s_axis_tdata[3:0];
    assign button = s_axis_tdata[4];

    always_comb begin
        meas         = classify(mask);
        need         = (r_cfg.confirm == 4'd0) ? 4'd1 : r_cfg.confirm;
        n_primed     = r_primed;
        n_cand       = r_cand;
        n_stable     = r_stable;
        n_reps       = r_reps;
        n_run        = r_run;
        n_state      = r_state;
        n_lost_ticks = r_lost_ticks;
        n_lost_act   = r_lost_act;
        lost_count   = '0;

        if (meas == CLS_LOST) begin
            obs = CLS_LOST;
        end else if (!r_primed) begin
            n_primed = 1'b1;
            n_cand   = meas;
            n_stable = meas;
            n_reps   = need;
            obs      = meas;
        end else begin
            n_cand = meas;
            if (meas != r_cand) begin
                n_reps = 4'd1;
            end else if (r_reps < need) begin
                n_reps = r_reps + 4'd1;
            end
            if (n_reps >= need) begin
                n_stable = meas;
            end
            obs = n_stable;
        end

        if (button) begin
            if (r_run) begin
                n_run   = 1'b0;
                n_state = ST_STOPPED;
            end else if (obs == CLS_LOST || obs == CLS_AMBIG) begin
                n_state = ST_FAULT;
            end else begin
                n_run        = 1'b1;
                n_lost_act   = 1'b0;
                n_lost_ticks = '0;
            end
        end

        if (n_run) begin
            if (obs == CLS_LOST) begin
                lost_count = n_lost_act ? n_lost_ticks : 8'd0;
                n_lost_act = 1'b1;
                if (lost_count >= r_cfg.lost_delay) begin
                    n_run        = 1'b0;
                    n_state      = ST_FAULT;
                    n_lost_ticks = lost_count;
                end else begin
                    n_state      = ST_LOST_FWD;
                    n_lost_ticks = lost_count + 8'd1;
                end
            end else if (obs == CLS_AMBIG) begin
                n_run   = 1'b0;
                n_state = ST_FAULT;
            end else begin
                n_lost_act   = 1'b0;
                n_lost_ticks = '0;
                unique case (obs)
                    CLS_CENTER:   n_state = ST_TRACK;
                    CLS_LEFT:     n_state = ST_CORR_LEFT;
                    CLS_RIGHT:    n_state = ST_CORR_RIGHT;
                    CLS_FAR_LEFT: n_state = ST_RECOV_LEFT;
                    default:      n_state = ST_RECOV_RIGHT;
                endcase
            end
        end
    end

    ltsc_cmd u_cmd (
        .i_state (n_state),
        .i_cfg   (r_cfg),
        .o_left  (left_cmd),
        .o_right (right_cmd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.left_base  <= RST_LEFT_BASE;
            r_cfg.right_base <= RST_RIGHT_BASE;
            r_cfg.soft_corr  <= RST_SOFT_CORR;
            r_cfg.hard_corr  <= RST_HARD_CORR;
            r_cfg.min_power  <= RST_MIN_POWER;
            r_cfg.confirm    <= RST_CONFIRM;
            r_cfg.lost_delay <= RST_LOST_DELAY;
            r_cfg.reverse    <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LEFT_BASE:  r_cfg.left_base  <= i_cfg_data[POWER_W-1:0];
                CFG_RIGHT_BASE: r_cfg.right_base <= i_cfg_data[POWER_W-1:0];
                CFG_SOFT_CORR:  r_cfg.soft_corr  <= i_cfg_data[POWER_W-1:0];
                CFG_HARD_CORR:  r_cfg.hard_corr  <= i_cfg_data[POWER_W-1:0];
                CFG_MIN_POWER:  r_cfg.min_power  <= i_cfg_data[POWER_W-1:0];
                CFG_CONFIRM:    r_cfg.confirm    <= i_cfg_data[3:0];
                CFG_LOST_DELAY: r_cfg.lost_delay <= i_cfg_data[7:0];
                CFG_REVERSE:    r_cfg.reverse    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run        <= 1'b0;
            r_state      <= ST_STOPPED;
            r_primed     <= 1'b0;
            r_cand       <= CLS_CENTER;
            r_stable     <= CLS_CENTER;
            r_reps       <= '0;
            r_lost_ticks <= '0;
            r_lost_act   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (in_accept) begin
                r_run        <= n_run;
                r_state      <= n_state;
                r_primed     <= n_primed;
                r_cand       <= n_cand;
                r_stable     <= n_stable;
                r_reps       <= n_reps;
                r_lost_ticks <= n_lost_ticks;
                r_lost_act   <= n_lost_act;
                r_out_valid  <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_data <= {1'b0, right_cmd, left_cmd, obs, n_run, n_state};
        end
    end

    // A running result always carries one of the tracking states.
    a_run_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data[3] |->
            r_out_data[2:0] != ST_STOPPED && r_out_data[2:0] != ST_FAULT)
        else $error("running result with stopped or fault state");

    // Stopped and fault give zero wheel commands.
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_data[2:0] == ST_STOPPED || r_out_data[2:0] == ST_FAULT)
            |-> r_out_data[22:7] == 16'd0)
        else $error("nonzero command while stopped or faulted");

    // Lost forward is only entered on a lost observation.
    a_lost_obs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data[2:0] == ST_LOST_FWD |-> r_out_data[6:4] == CLS_LOST)
        else $error("lost forward without a lost observation");

    // Every accepted request shows a result in the next cycle.
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_out_valid)
        else $error("accepted request produced no result");

    // Left command is never negative and right command never positive.
    a_cmd_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !r_out_data[14] && !(r_out_data[22:15] != 8'd0 && !r_out_data[22]))
        else $error("wheel command with wrong sign");

endmodule

>>> tb/tb_line_tracking_steering_controller_core.sv
// ----------------------------------------------------------------------------
// Line tracking steering controller testbench
// Sends control ticks into the controller and checks every wheel command
// result against a cycle-free prediction of the classifier, the confirmation
// filter, the run rules and the power shaping. Register settings change
// between phases, and both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_line_tracking_steering_controller_core;
    import ltsc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam logic [3:0] TRACK_MASKS [9] = '{4'h6, 4'h7, 4'hE, 4'h4, 4'h2,
                                               4'h8, 4'hC, 4'h1, 4'h3};

    typedef struct {
        t_state             st;
        logic               run;
        t_class             obs;
        logic signed [7:0]  lcmd;
        logic signed [7:0]  rcmd;
    } t_tick_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [23:0]           m_axis_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    t_tick_result steer_queue[$];
    t_tick_result head_result;

    t_cfg   mdl_cfg;
    logic   mdl_run;
    t_state mdl_state;
    logic   mdl_primed;
    t_class mdl_cand;
    t_class mdl_stable;
    int     mdl_cand_cnt;
    int     mdl_lost_cnt;
    logic   mdl_lost_on;

    int errors = 0;
    int cycles = 0;
    int n_ticks = 0;
    int n_settings = 0;
    int idle_mode = 0;
    int hold_request = 0;

    line_tracking_steering_controller_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic int idle_pct(bit rx_side);
        case (idle_mode)
            1: return rx_side ? 0 : 77;
            2: return rx_side ? 77 : 0;
            3: return 29;
            default: return 0;
        endcase
    endfunction

    task automatic model_reset();
        mdl_cfg.left_base  = RST_LEFT_BASE;
        mdl_cfg.right_base = RST_RIGHT_BASE;
        mdl_cfg.soft_corr  = RST_SOFT_CORR;
        mdl_cfg.hard_corr  = RST_HARD_CORR;
        mdl_cfg.min_power  = RST_MIN_POWER;
        mdl_cfg.confirm    = RST_CONFIRM;
        mdl_cfg.lost_delay = RST_LOST_DELAY;
        mdl_cfg.reverse    = 1'b0;
        mdl_run      = 1'b0;
        mdl_state    = ST_STOPPED;
        mdl_primed   = 1'b0;
        mdl_cand     = CLS_CENTER;
        mdl_stable   = CLS_CENTER;
        mdl_cand_cnt = 0;
        mdl_lost_cnt = 0;
        mdl_lost_on  = 1'b0;
    endtask

    function automatic t_class classify_mask(logic [3:0] m);
        if (m == 4'h0) return CLS_LOST;
        if (m[3] && m[0]) return CLS_AMBIG;
        if (m[2] && m[1]) return CLS_CENTER;
        if ((m[3] && m[1]) || (m[0] && m[2])) return CLS_AMBIG;
        if (m[3]) return CLS_FAR_LEFT;
        if (m[0]) return CLS_FAR_RIGHT;
        if (m[2]) return CLS_LEFT;
        return CLS_RIGHT;
    endfunction

    function automatic int wheel_power(int p);
        int lo;
        lo = int'(mdl_cfg.min_power);
        if (p <= 0) return 0;
        if (p < lo) p = lo;
        if (p > 100) p = 100;
        return p;
    endfunction

    task automatic steer_predict(input logic [3:0] mask, input logic btn);
        t_class       meas;
        t_class       obs;
        t_tick_result res;
        int           need;
        int           d;
        int           c;
        bit           moving;
        meas = classify_mask(mask);
        need = (mdl_cfg.confirm == 4'd0) ? 1 : int'(mdl_cfg.confirm);
        if (meas == CLS_LOST) begin
            obs = CLS_LOST;
        end else begin
            if (!mdl_primed) begin
                mdl_primed   = 1'b1;
                mdl_cand     = meas;
                mdl_stable   = meas;
                mdl_cand_cnt = need;
            end else begin
                if (meas != mdl_cand) begin
                    mdl_cand     = meas;
                    mdl_cand_cnt = 1;
                end else if (mdl_cand_cnt < need) begin
                    mdl_cand_cnt++;
                end
                if (mdl_cand_cnt >= need) mdl_stable = mdl_cand;
            end
            obs = mdl_stable;
        end

        if (btn) begin
            if (mdl_run) begin
                mdl_run   = 1'b0;
                mdl_state = ST_STOPPED;
            end else if (obs == CLS_LOST || obs == CLS_AMBIG) begin
                mdl_state = ST_FAULT;
            end else begin
                mdl_run      = 1'b1;
                mdl_lost_on  = 1'b0;
                mdl_lost_cnt = 0;
            end
        end

        if (mdl_run) begin
            if (obs == CLS_LOST) begin
                if (!mdl_lost_on) begin
                    mdl_lost_on  = 1'b1;
                    mdl_lost_cnt = 0;
                end
                if (mdl_lost_cnt >= int'(mdl_cfg.lost_delay)) begin
                    mdl_run   = 1'b0;
                    mdl_state = ST_FAULT;
                end else begin
                    mdl_state = ST_LOST_FWD;
                    if (mdl_lost_cnt < 255) mdl_lost_cnt++;
                end
            end else if (obs == CLS_AMBIG) begin
                mdl_run   = 1'b0;
                mdl_state = ST_FAULT;
            end else begin
                mdl_lost_on  = 1'b0;
                mdl_lost_cnt = 0;
                case (obs)
                    CLS_CENTER:   mdl_state = ST_TRACK;
                    CLS_LEFT:     mdl_state = ST_CORR_LEFT;
                    CLS_RIGHT:    mdl_state = ST_CORR_RIGHT;
                    CLS_FAR_LEFT: mdl_state = ST_RECOV_LEFT;
                    default:      mdl_state = ST_RECOV_RIGHT;
                endcase
            end
        end

        d = 0;
        c = 0;
        moving = 1'b1;
        case (mdl_state)
            ST_TRACK, ST_LOST_FWD: ;
            ST_CORR_LEFT: begin
                d = -1;
                c = int'(mdl_cfg.soft_corr);
            end
            ST_CORR_RIGHT: begin
                d = 1;
                c = int'(mdl_cfg.soft_corr);
            end
            ST_RECOV_LEFT: begin
                d = -1;
                c = int'(mdl_cfg.hard_corr);
            end
            ST_RECOV_RIGHT: begin
                d = 1;
                c = int'(mdl_cfg.hard_corr);
            end
            default: moving = 1'b0;
        endcase
        if (mdl_cfg.reverse) d = -d;

        res.st  = mdl_state;
        res.run = mdl_run;
        res.obs = obs;
        if (moving) begin
            res.lcmd = 8'(wheel_power(int'(mdl_cfg.left_base) + d * c));
            res.rcmd = 8'(-wheel_power(int'(mdl_cfg.right_base) - d * c));
        end else begin
            res.lcmd = '0;
            res.rcmd = '0;
        end
        steer_queue.push_back(res);
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    // Results are checked before new requests are predicted, so one edge never
    // depends on process order.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            model_reset();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (steer_queue.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, m_axis_tdata);
                end else begin
                    head_result = steer_queue.pop_front();
                    check_field("line_state", head_result.st, m_axis_tdata[2:0]);
                    check_field("running", head_result.run, m_axis_tdata[3]);
                    check_field("observation", head_result.obs, m_axis_tdata[6:4]);
                    check_field("left_wheel", head_result.lcmd,
                                $signed(m_axis_tdata[14:7]));
                    check_field("right_wheel", head_result.rcmd,
                                $signed(m_axis_tdata[22:15]));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                n_ticks++;
                steer_predict(s_axis_tdata[3:0], s_axis_tdata[4]);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_LEFT_BASE:  mdl_cfg.left_base  = i_cfg_data[POWER_W-1:0];
                    CFG_RIGHT_BASE: mdl_cfg.right_base = i_cfg_data[POWER_W-1:0];
                    CFG_SOFT_CORR:  mdl_cfg.soft_corr  = i_cfg_data[POWER_W-1:0];
                    CFG_HARD_CORR:  mdl_cfg.hard_corr  = i_cfg_data[POWER_W-1:0];
                    CFG_MIN_POWER:  mdl_cfg.min_power  = i_cfg_data[POWER_W-1:0];
                    CFG_CONFIRM:    mdl_cfg.confirm    = i_cfg_data[3:0];
                    CFG_LOST_DELAY: mdl_cfg.lost_delay = i_cfg_data[7:0];
                    CFG_REVERSE:    mdl_cfg.reverse    = i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Output side: random stalls, plus a long hold-off counted here on request.
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                hold = hold_request;
                hold_request = 0;
            end
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= idle_pct(1'b1));
            end
        end
    end

    task automatic send_tick(input logic [3:0] mask, input logic btn);
        int gap;
        int pct;
        gap = 0;
        pct = idle_pct(1'b0);
        while (pct > 0 && $urandom_range(99) < pct) gap++;
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, btn, mask};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load_settings(input int lb, input int rb, input int sc, input int hc,
                                 input int mp, input int cf, input int ld, input int rv);
        write_reg(CFG_LEFT_BASE, 8'(lb));
        write_reg(CFG_RIGHT_BASE, 8'(rb));
        write_reg(CFG_SOFT_CORR, 8'(sc));
        write_reg(CFG_HARD_CORR, 8'(hc));
        write_reg(CFG_MIN_POWER, 8'(mp));
        write_reg(CFG_CONFIRM, 8'(cf));
        write_reg(CFG_LOST_DELAY, 8'(ld));
        write_reg(CFG_REVERSE, 8'(rv));
        n_settings++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (steer_queue.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Mostly confirmed runs of trackable masks, with loss bursts and noise.
    task automatic drive_random(input int n);
        int sent;
        int pick;
        int len;
        int span;
        logic [3:0] m;
        sent = 0;
        while (sent < n) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                m = TRACK_MASKS[$urandom_range(8)];
                span = (mdl_cfg.confirm == 4'd0) ? 1 : int'(mdl_cfg.confirm);
                len = $urandom_range(1, span + 2);
                repeat (len) begin
                    send_tick(m, $urandom_range(99) < (mdl_run ? 3 : 25));
                    sent++;
                end
            end else if (pick < 82) begin
                span = (mdl_cfg.lost_delay > 8'd8) ? 8 : int'(mdl_cfg.lost_delay);
                len = $urandom_range(1, span + 2);
                repeat (len) begin
                    send_tick(4'h0, $urandom_range(99) < 5);
                    sent++;
                end
            end else begin
                send_tick(4'($urandom_range(15)), 1'($urandom_range(1)));
                sent++;
            end
        end
    endtask

    task automatic test_directed_defaults();
        idle_mode = 0;
        send_tick(4'h0, 1'b1);
        send_tick(4'h6, 1'b0);
        send_tick(4'h6, 1'b1);
        send_tick(4'h4, 1'b0);
        send_tick(4'h4, 1'b0);
        send_tick(4'h2, 1'b0);
        send_tick(4'h2, 1'b0);
        send_tick(4'h8, 1'b0);
        send_tick(4'hC, 1'b0);
        send_tick(4'h1, 1'b0);
        send_tick(4'h3, 1'b0);
        send_tick(4'h7, 1'b0);
        send_tick(4'hE, 1'b0);
        send_tick(4'hF, 1'b0);
        send_tick(4'hF, 1'b0);
        send_tick(4'h6, 1'b1);
        send_tick(4'h0, 1'b0);
        send_tick(4'h6, 1'b1);
        send_tick(4'h6, 1'b1);
        send_tick(4'h5, 1'b0);
        send_tick(4'h9, 1'b0);
        send_tick(4'hA, 1'b1);
        send_tick(4'hB, 1'b0);
        send_tick(4'hD, 1'b0);
    endtask

    task automatic test_long_loss();
        wait_idle();
        idle_mode = 0;
        load_settings(60, 40, 20, 45, 30, 1, 255, 1);
        send_tick(4'h6, 1'b1);
        repeat (258) send_tick(4'h0, 1'b0);
        send_tick(4'h6, 1'b1);
    endtask

    task automatic test_random_phases();
        int ph;
        for (ph = 0; ph < 8; ph++) begin
            wait_idle();
            case (ph)
                0: load_settings(0, 0, 0, 0, 0, 0, 0, 0);
                1: load_settings(127, 127, 127, 127, 127, 15, 255, 1);
                2: load_settings(100, 100, 100, 100, 100, 1, 1, 0);
                3: load_settings(50, 50, 15, 30, 35, 2, 0, 0);
                default: load_settings($urandom_range(127), $urandom_range(127),
                                       $urandom_range(127), $urandom_range(127),
                                       $urandom_range(127), $urandom_range(4),
                                       $urandom_range(5), $urandom_range(1));
            endcase
            idle_mode = ph % 4;
            drive_random(24);
        end
    endtask

    task automatic test_backpressure();
        wait_idle();
        idle_mode = 0;
        load_settings(70, 55, 25, 40, 20, 1, 3, 0);
        hold_request = 300;
        repeat (40) send_tick(TRACK_MASKS[$urandom_range(8)], $urandom_range(99) < 10);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_defaults();
        test_long_loss();
        test_random_phases();
        test_backpressure();
        wait_idle();
        $display("Ran %0d control ticks under %0d register settings,", n_ticks, n_settings);
        $display("with all idle patterns, a long line loss and a long output stall.");
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
